>>> rtl/fbfl_pkg.sv
`timescale 1ns / 1ps

package fbfl_pkg;

  // Width of the block count register and of the free and fresh counters.
  localparam int CNT_W = 7;
  // Width of the block index ports.
  localparam int IDX_PORT_W = 6;
  // Width of the status port.
  localparam int STATUS_W = 2;

  localparam int DEFAULT_MAX_BLOCKS = 64;
  localparam logic [CNT_W-1:0] BLOCK_COUNT_RESET = 7'd64;
  localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // A programmed count above the pool capacity acts as the capacity.
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] bc,
                                                 input int unsigned maxb);
    logic [31:0] maxb_v;
    maxb_v = maxb;
    if (32'(bc) > maxb_v) begin
      return maxb_v[CNT_W-1:0];
    end
    return bc;
  endfunction

endpackage

>>> rtl/fbfl_ram.sv
`timescale 1ns / 1ps

module fbfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/fixed_block_free_list_allocator.sv
`timescale 1ns / 1ps

// Fixed-block pool allocator with a LIFO free list kept in a link memory.
// Request channel (in_valid/in_ready): func selects allocate or free, and
// block_index names the block to free. Every request gives exactly one result
// on the output channel (out_valid/out_ready): status, granted_index and the
// free block count after the request.
// Configuration channel (cfg_valid/cfg_ready): writing block_count
// reinitializes the pool; it is taken only while no request is in progress.
// On a request, the accept edge also reads the link memory at the list head
// and enters the execute state; the execute state then does the update and
// loads the result register once the output register is free or being taken.
// The link memory read is registered, hence the separate execute state.
// Reset empties the free list and restores a block count of 64; the link
// memory keeps its contents, since only written entries are ever read.
// When the receiver stalls, the result waits in the output register while one
// more request is accepted; that request holds until the result is taken.

module fixed_block_free_list_allocator
  import fbfl_pkg::*;
#(
  parameter int MAX_BLOCKS = DEFAULT_MAX_BLOCKS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_W-1:0]      block_count,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  func,
  input  logic [IDX_PORT_W-1:0] block_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   status,
  output logic [IDX_PORT_W-1:0] granted_index,
  output logic [CNT_W-1:0]      free_blocks
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                  state;
  logic [CNT_W-1:0]      pool_size;
  logic [IW-1:0]         list_head;
  logic                  list_nonempty;
  logic [CNT_W-1:0]      fresh_remaining;
  logic [CNT_W-1:0]      free_total;
  logic                  req_func;
  logic [IDX_PORT_W-1:0] req_index;

  logic [CNT_W-1:0]      n_eff;
  logic [CNT_W-1:0]      cfg_n;
  logic                  in_fire;
  logic                  cfg_fire;
  logic                  go;
  logic [31:0]           idx32;
  logic [31:0]           head32;
  logic [IW-1:0]         req_idx_w;
  logic [CNT_W-1:0]      fresh_dec;
  logic                  mem_we;
  logic [IW-1:0]         mem_rdata;

  logic [IW-1:0]         list_head_next;
  logic                  list_nonempty_next;
  logic [CNT_W-1:0]      fresh_remaining_next;
  logic [CNT_W-1:0]      free_total_next;
  logic [STATUS_W-1:0]   status_next;
  logic [IDX_PORT_W-1:0] granted_next;

  assign n_eff     = eff_count(pool_size, MAX_BLOCKS);
  assign cfg_n     = eff_count(block_count, MAX_BLOCKS);
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign go        = (state == S_EXEC) && (!out_valid || out_ready);
  assign idx32     = 32'(req_index);
  assign head32    = 32'(list_head);
  assign req_idx_w = idx32[IW-1:0];
  assign fresh_dec = fresh_remaining - 7'd1;

  // The link at the current head is fetched on the accept edge, so the pop
  // has it ready in the execute cycle. No write lands between the two.
  fbfl_ram #(
    .WIDTH(IW),
    .DEPTH(MAX_BLOCKS)
  ) u_link_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(req_idx_w),
    .wdata(list_nonempty ? list_head : req_idx_w),
    .re   (in_fire),
    .raddr(list_head),
    .rdata(mem_rdata)
  );

  always_comb begin
    list_head_next       = list_head;
    list_nonempty_next   = list_nonempty;
    fresh_remaining_next = fresh_remaining;
    free_total_next      = free_total;
    status_next          = ST_OK;
    granted_next         = '0;
    mem_we               = 1'b0;
    if (req_func == FUNC_ALLOC) begin
      if (list_nonempty) begin
        granted_next = head32[IDX_PORT_W-1:0];
        if (mem_rdata == list_head) begin
          list_nonempty_next = 1'b0;
          list_head_next     = '0;
        end else begin
          list_head_next = mem_rdata;
        end
        if (free_total != '0) begin
          free_total_next = free_total - 7'd1;
        end
      end else if (fresh_remaining != '0) begin
        fresh_remaining_next = fresh_dec;
        granted_next         = fresh_dec[IDX_PORT_W-1:0];
        if (free_total != '0) begin
          free_total_next = free_total - 7'd1;
        end
      end else begin
        status_next = ST_EMPTY;
      end
    end else begin
      if (32'(req_index) >= 32'(n_eff)) begin
        status_next = ST_RANGE;
      end else begin
        mem_we             = go;
        list_head_next     = req_idx_w;
        list_nonempty_next = 1'b1;
        if (free_total != CNT_MAX) begin
          free_total_next = free_total + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      pool_size       <= BLOCK_COUNT_RESET;
      list_head       <= '0;
      list_nonempty   <= 1'b0;
      fresh_remaining <= eff_count(BLOCK_COUNT_RESET, MAX_BLOCKS);
      free_total      <= eff_count(BLOCK_COUNT_RESET, MAX_BLOCKS);
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_fire) begin
        pool_size       <= block_count;
        list_head       <= '0;
        list_nonempty   <= 1'b0;
        fresh_remaining <= cfg_n;
        free_total      <= cfg_n;
      end
      if (in_fire) begin
        state <= S_EXEC;
      end
      if (go) begin
        state           <= S_IDLE;
        list_head       <= list_head_next;
        list_nonempty   <= list_nonempty_next;
        fresh_remaining <= fresh_remaining_next;
        free_total      <= free_total_next;
        out_valid       <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_func  <= func;
      req_index <= block_index;
    end
    if (go) begin
      status        <= status_next;
      granted_index <= granted_next;
      free_blocks   <= free_total_next;
    end
  end

  // An empty free list always parks its head at zero.
  assert property (@(posedge clk) disable iff (rst)
    !list_nonempty |-> list_head == '0)
    else $error("free list head not parked while list is empty");

  // Fresh blocks never exceed the configured pool.
  assert property (@(posedge clk) disable iff (rst)
    fresh_remaining <= n_eff)
    else $error("fresh block count beyond pool size");

  // A result that is not ok never carries a granted index.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> granted_index == '0)
    else $error("granted index set on a failed request");

  // A stalled result must not be overwritten by the pending request.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(granted_index) && $stable(free_blocks))
    else $error("held result changed under stall");

  // Every accepted request completes in the execute state before the next.
  assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == S_EXEC && !in_ready)
    else $error("request accepted without entering execute");

endmodule

>>> tb/fixed_block_free_list_allocator_test.sv
`timescale 1ns / 1ps

module fixed_block_free_list_allocator_test;
  import fbfl_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [IDX_PORT_W-1:0] granted;
    logic [CNT_W-1:0]      free_cnt;
  } alloc_result_t;

  localparam int STUCK_LIMIT = 2000;
  localparam int LONG_STALL = 150;
  localparam int RANDOM_REQUESTS = 1450;

  // Tracks the pool as the block should see it and queues the result that each
  // accepted request must produce.
  class pool_scoreboard;
    logic [IDX_PORT_W-1:0] link_mem [DEFAULT_MAX_BLOCKS];
    logic [IDX_PORT_W-1:0] head;
    logic                  listed;
    logic [CNT_W-1:0]      fresh;
    logic [CNT_W-1:0]      free_cnt;
    logic [CNT_W-1:0]      pool_size;
    alloc_result_t         results_due[$];
    int errors;
    int grants, frees, empties, rejects, floor_hits, ceiling_hits, sizes;

    function new();
      pool_size = BLOCK_COUNT_RESET;
      restart();
    endfunction

    function logic [CNT_W-1:0] usable();
      if (pool_size > CNT_W'(DEFAULT_MAX_BLOCKS)) begin
        return CNT_W'(DEFAULT_MAX_BLOCKS);
      end
      return pool_size;
    endfunction

    // The link memory keeps its old contents; only listed entries are read.
    function void restart();
      head = '0;
      listed = 1'b0;
      fresh = usable();
      free_cnt = usable();
    endfunction

    function void set_block_count(logic [CNT_W-1:0] v);
      pool_size = v;
      sizes++;
      restart();
    endfunction

    function void take_one();
      grants++;
      if (free_cnt != 0) begin
        free_cnt--;
      end else begin
        floor_hits++;
      end
    endfunction

    function alloc_result_t note_request(logic f, logic [IDX_PORT_W-1:0] idx);
      alloc_result_t r;
      logic [IDX_PORT_W-1:0] nxt;
      r = '0;
      r.status = ST_OK;
      if (f == FUNC_ALLOC) begin
        if (listed) begin
          nxt = link_mem[head];
          r.granted = head;
          // A block that links to itself is the last one on the list.
          if (nxt == head) begin
            listed = 1'b0;
            head = '0;
          end else begin
            head = nxt;
          end
          take_one();
        end else if (fresh != 0) begin
          fresh--;
          r.granted = fresh[IDX_PORT_W-1:0];
          take_one();
        end else begin
          r.status = ST_EMPTY;
          empties++;
        end
      end else if ({1'b0, idx} >= usable()) begin
        r.status = ST_RANGE;
        rejects++;
      end else begin
        link_mem[idx] = listed ? head : idx;
        head = idx;
        listed = 1'b1;
        frees++;
        if (free_cnt != CNT_MAX) begin
          free_cnt++;
        end else begin
          ceiling_hits++;
        end
      end
      r.free_cnt = free_cnt;
      results_due.push_back(r);
      return r;
    endfunction

    task report_mismatch(string what, alloc_result_t got, alloc_result_t want);
      errors++;
      if (errors <= 30) begin
        $display({"[%0t] %s: got status %0d index %0d free %0d,",
                  " expected status %0d index %0d free %0d"},
                 $time, what, got.status, got.granted, got.free_cnt,
                 want.status, want.granted, want.free_cnt);
      end
    endtask

    task check_result(alloc_result_t got);
      alloc_result_t want;
      if (results_due.size() == 0) begin
        report_mismatch("result with no request pending", got, '0);
      end else begin
        want = results_due.pop_front();
        if (got.status !== want.status) report_mismatch("status", got, want);
        if (got.granted !== want.granted) report_mismatch("granted_index", got, want);
        if (got.free_cnt !== want.free_cnt) report_mismatch("free_blocks", got, want);
      end
    endtask

    task check_drained();
      while (results_due.size() != 0) begin
        report_mismatch("result never delivered", '0, results_due.pop_front());
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CNT_W-1:0]      block_count = BLOCK_COUNT_RESET;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  func = FUNC_ALLOC;
  logic [IDX_PORT_W-1:0] block_index = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [IDX_PORT_W-1:0] granted_index;
  logic [CNT_W-1:0]      free_blocks;

  pool_scoreboard board = new();
  logic [IDX_PORT_W-1:0] held[$];
  logic no_gaps = 1'b0;
  logic hold_wanted = 1'b0;
  int stuck_cycles = 0;
  int requests_sent = 0;

  fixed_block_free_list_allocator dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .block_count(block_count),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .block_index(block_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .granted_index(granted_index),
    .free_blocks(free_blocks)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles", $time, STUCK_LIMIT);
      $display("fixed_block_free_list_allocator_test: FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_request(input logic f, input logic [IDX_PORT_W-1:0] idx);
    int gap;
    alloc_result_t want;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    block_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = board.note_request(f, idx);
    if (f == FUNC_ALLOC && want.status == ST_OK) held.push_back(want.granted);
    requests_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_block_count(input logic [CNT_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    block_count <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.set_block_count(v);
    held.delete();
  endtask

  // Mostly frees of blocks we hold and allocations, with a few stray frees
  // that may be out of range or free a block twice.
  task automatic pick_request(output logic f, output logic [IDX_PORT_W-1:0] idx);
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      f = FUNC_FREE;
      idx = IDX_PORT_W'($urandom_range(0, 63));
    end else if (held.size() > 0 && r < 53) begin
      k = $urandom_range(0, held.size() - 1);
      f = FUNC_FREE;
      idx = held[k];
      held.delete(k);
    end else begin
      f = FUNC_ALLOC;
      idx = IDX_PORT_W'($urandom);
    end
  endtask

  initial begin
    int stall;
    alloc_result_t got;
    wait (!rst);
    forever begin
      stall = hold_wanted ? LONG_STALL : (no_gaps ? 0 : $urandom_range(0, 12));
      hold_wanted = 1'b0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = {status, granted_index, free_blocks};
      board.check_result(got);
    end
  end

  initial begin
    int phase;
    int len;
    int random_sent;
    logic f;
    logic [IDX_PORT_W-1:0] idx;
    logic [CNT_W-1:0] size_pick;
    phase = 0;
    random_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fresh pool of 64: grants count down from the top, freed blocks come back
    // first, and the list empties when its self-linked tail is popped.
    send_request(FUNC_ALLOC, 6'd0);
    send_request(FUNC_FREE, 6'd63);
    send_request(FUNC_ALLOC, 6'd63);
    send_request(FUNC_ALLOC, 6'd0);
    send_request(FUNC_FREE, 6'd0);
    send_request(FUNC_FREE, 6'd62);
    send_request(FUNC_ALLOC, 6'd21);
    send_request(FUNC_ALLOC, 6'd42);
    send_request(FUNC_ALLOC, 6'd63);

    // A zero-sized pool rejects everything.
    write_block_count(7'd0);
    send_request(FUNC_ALLOC, 6'd0);
    send_request(FUNC_FREE, 6'd0);
    send_request(FUNC_FREE, 6'd63);

    // Counts above capacity act as capacity.
    write_block_count(CNT_MAX);
    send_request(FUNC_FREE, 6'd63);
    send_request(FUNC_ALLOC, 6'd0);

    write_block_count(7'd1);
    send_request(FUNC_ALLOC, 6'd0);
    send_request(FUNC_ALLOC, 6'd0);
    send_request(FUNC_FREE, 6'd1);
    send_request(FUNC_FREE, 6'd0);

    // Freeing 0, 1, 0 makes a loop in the list, so grants never run out and
    // the free count has to stop at zero.
    write_block_count(7'd2);
    send_request(FUNC_ALLOC, 6'd0);
    send_request(FUNC_ALLOC, 6'd0);
    send_request(FUNC_FREE, 6'd0);
    send_request(FUNC_FREE, 6'd1);
    send_request(FUNC_FREE, 6'd0);
    repeat (5) send_request(FUNC_ALLOC, 6'd0);

    while (random_sent < RANDOM_REQUESTS) begin
      case ($urandom_range(0, 9))
        0: size_pick = 7'd0;
        1: size_pick = 7'd1;
        2: size_pick = 7'd64;
        3: size_pick = CNT_MAX;
        4: size_pick = CNT_W'($urandom_range(65, 127));
        default: size_pick = CNT_W'($urandom_range(2, 63));
      endcase
      if (phase == 0) size_pick = 7'd64;
      write_block_count(size_pick);
      no_gaps = ($urandom_range(0, 3) == 0);
      len = (phase == 0) ? 160 : $urandom_range(40, 160);
      for (int k = 0; k < len; k++) begin
        // The first phase opens with a flood of frees that drives the free
        // count into its upper limit.
        if (phase == 0 && k < 70) begin
          f = FUNC_FREE;
          idx = IDX_PORT_W'($urandom_range(0, 63));
        end else begin
          pick_request(f, idx);
        end
        if (phase == 1 && k == 10) hold_wanted = 1'b1;
        send_request(f, idx);
        random_sent++;
      end
      phase++;
    end

    drain();
    repeat (10) @(posedge clk);
    board.check_drained();
    $display("Ran %0d requests over %0d pool sizes: %0d grants, %0d frees,",
             requests_sent, board.sizes, board.grants, board.frees);
    $display("%0d empty, %0d out of range; free count held at zero on %0d grants%s%0d frees.",
             board.empties, board.rejects, board.floor_hits, " and at its top on ",
             board.ceiling_hits);
    if (board.errors == 0) begin
      $display("fixed_block_free_list_allocator_test: PASS");
    end else begin
      $display("fixed_block_free_list_allocator_test: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/fbfl_pkg.sv
rtl/fbfl_ram.sv
rtl/fixed_block_free_list_allocator.sv
tb/fixed_block_free_list_allocator_test.sv
